@@ rtl/lbp_code_stream_unit_assert.svh @@
// ----------------------------------------------------------------------------
// lbp_code_stream_unit_assert.svh
// Assertion macros used by the LBP code stream RTL. They expect signals
// named clock and reset in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef LBP_CODE_STREAM_UNIT_ASSERT_SVH
`define LBP_CODE_STREAM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants and types of the LBP code stream unit.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int EFF_W      = COL_W + 1;
   localparam int PIX_W      = 8;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int ROW_W      = 16;
   localparam int CODE_W     = 8;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(128);
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(64);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One column of the 3x3 window.
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } win_col_type;

   // Per-beat markers that travel down the pipeline with the pixel.
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } tag_type;

endpackage

@@ rtl/lbp_req_if.sv @@
// ----------------------------------------------------------------------------
// lbp_req_if
// Pixel input channel: valid/ready handshake carrying one grey pixel a beat.
// ----------------------------------------------------------------------------
interface lbp_req_if;

   logic                       valid;
   logic                       ready;
   logic [lbp_pkg::PIX_W-1:0]  pixel;
   logic                       frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);

endinterface

@@ rtl/lbp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lbp_rsp_if
// Code output channel: valid/ready handshake carrying one LBP code a beat.
// ----------------------------------------------------------------------------
interface lbp_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [lbp_pkg::CODE_W-1:0]  lbp_code;
   logic                        row_end;
   logic                        frame_end;

   modport source (output valid, output lbp_code, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input lbp_code, input row_end, input frame_end,
                   output ready);

endinterface

@@ rtl/lbp_cell.sv @@
// ----------------------------------------------------------------------------
// lbp_cell
// One column cell of the sliding 3x3 window. It loads a column from its
// right neighbor on each shift and compares its three pixels to the center.
// ----------------------------------------------------------------------------
module lbp_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  lbp_pkg::win_col_type        col_in,
   input  logic [lbp_pkg::PIX_W-1:0]   centre,
   output lbp_pkg::win_col_type        col_out,
   output logic [2:0]                  gt_bits
);

   lbp_pkg::win_col_type col_ff;
   lbp_pkg::win_col_type col_in_w;

   always_comb begin
      col_in_w = shift_en ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_w;
      end
   end

   assign col_out = col_ff;

   // Bit 2 is the top pixel, bit 1 the middle one, bit 0 the bottom one.
   assign gt_bits = {col_ff.top > centre, col_ff.mid > centre, col_ff.bot > centre};

endmodule

@@ rtl/lbp_line_buf.sv @@
// ----------------------------------------------------------------------------
// lbp_line_buf
// Two line stores holding the previous two image rows. Reads are registered;
// a read that meets a write to the same column in the same cycle is served
// from a forwarding register.
// ----------------------------------------------------------------------------
module lbp_line_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [lbp_pkg::COL_W-1:0]   rd_addr,
   input  logic                        wr_en,
   input  logic [lbp_pkg::COL_W-1:0]   wr_addr,
   input  logic [lbp_pkg::PIX_W-1:0]   wr_up,
   input  logic [lbp_pkg::PIX_W-1:0]   wr_mid,
   output logic [lbp_pkg::PIX_W-1:0]   rd_up,
   output logic [lbp_pkg::PIX_W-1:0]   rd_mid
);

   logic [lbp_pkg::PIX_W-1:0] up_mem  [lbp_pkg::MAX_WIDTH];
   logic [lbp_pkg::PIX_W-1:0] mid_mem [lbp_pkg::MAX_WIDTH];

   logic [lbp_pkg::PIX_W-1:0] up_q_ff;
   logic [lbp_pkg::PIX_W-1:0] mid_q_ff;
   logic [lbp_pkg::PIX_W-1:0] fwd_up_ff;
   logic [lbp_pkg::PIX_W-1:0] fwd_mid_ff;
   logic                      hit_ff;
   logic                      hit_in;

   assign hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         up_mem[wr_addr]  <= wr_up;
         mid_mem[wr_addr] <= wr_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_q_ff    <= up_mem[rd_addr];
         mid_q_ff   <= mid_mem[rd_addr];
         fwd_up_ff  <= wr_up;
         fwd_mid_ff <= wr_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= hit_in;
      end
   end

   assign rd_up  = hit_ff ? fwd_up_ff  : up_q_ff;
   assign rd_mid = hit_ff ? fwd_mid_ff : mid_q_ff;

endmodule

@@ rtl/lbp_code_stream_unit.sv @@
// ----------------------------------------------------------------------------
// lbp_code_stream_unit
// Streaming 3x3 eight-neighbor local binary pattern over a raster pixel
// stream, built from two line stores and a chain of three window cells.
// ----------------------------------------------------------------------------
// Usage: pixels enter on req_chan, one grey pixel a beat in raster order,
// with frame_start set on the first pixel of a frame. Codes leave on
// rsp_chan, one beat for every interior pixel, in raster order; row_end
// marks the last code of an output row and frame_end the last code of the
// frame. Border pixels are taken but yield no beat.
// Frame width and height are written through the csr_ port while the block
// is idle; widths are clamped to 3..2048 and heights to at least 3.
// A code appears on rsp_chan once the pixel right below and to the right
// of its center has passed stage 1 and the window into the result register.
// Throughput is one pixel every cycle while the receiver does not stall:
// each line store takes one read, when a pixel is taken, and one write,
// as that pixel leaves stage 1. When the receiver stalls, the result
// register holds its beat and the two pipeline stages behind it fill up;
// req_chan.ready drops only once all of them are full. Reset clears the
// window, the position counters, all valid flags and restores the default
// frame size; line store contents are kept and need no clearing pass.
// ----------------------------------------------------------------------------
`include "lbp_code_stream_unit_assert.svh"

module lbp_code_stream_unit (
   input  logic                              clock,
   input  logic                              reset,
   lbp_req_if.sink                           req_chan,
   lbp_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [0:0]                        csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [lbp_pkg::CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [lbp_pkg::CFG_HEIGHT_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lbp_pkg::WIDTH_RESET;
         frame_height_ff <= lbp_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         if (csr_index == lbp_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[lbp_pkg::CFG_WIDTH_W-1:0];
         end
         if (csr_index == lbp_pkg::CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata[lbp_pkg::CFG_HEIGHT_W-1:0];
         end
      end
   end

   // Effective frame size: the last column and last row index. Widths are
   // clamped into the line store depth and heights held to at least three.
   logic [lbp_pkg::EFF_W-1:0] eff_width;
   logic [lbp_pkg::COL_W-1:0] col_last;
   logic [lbp_pkg::ROW_W-1:0] row_last;

   always_comb begin
      if (32'(frame_width_ff) < 32'd3) begin
         eff_width = lbp_pkg::EFF_W'(3);
      end else if (32'(frame_width_ff) > 32'(lbp_pkg::MAX_WIDTH)) begin
         eff_width = lbp_pkg::EFF_W'(lbp_pkg::MAX_WIDTH);
      end else begin
         eff_width = lbp_pkg::EFF_W'(frame_width_ff);
      end
      col_last = lbp_pkg::COL_W'(eff_width - lbp_pkg::EFF_W'(1));
      if (frame_height_ff < lbp_pkg::CFG_HEIGHT_W'(3)) begin
         row_last = lbp_pkg::ROW_W'(2);
      end else begin
         row_last = lbp_pkg::ROW_W'(frame_height_ff - lbp_pkg::CFG_HEIGHT_W'(1));
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control. Stage 1 waits for the line store read, stage 2
   // is the window itself, and the result register drives rsp_chan.
   // ------------------------------------------------------------------------
   logic                      s1_valid_ff;
   logic                      s2_valid_ff;
   logic                      rsp_valid_ff;
   lbp_pkg::tag_type          s1_tag_ff;
   lbp_pkg::tag_type          s2_tag_ff;
   logic [lbp_pkg::COL_W-1:0] s1_col_ff;
   logic [lbp_pkg::PIX_W-1:0] s1_pixel_ff;

   logic req_accept;
   logic rsp_free;
   logic s2_go;
   logic s2_free;
   logic s1_go;
   logic req_ready;

   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s2_go      = s2_valid_ff && (!s2_tag_ff.emit || rsp_free);
   assign s2_free    = !s2_valid_ff || s2_go;
   assign s1_go      = s1_valid_ff && s2_free;
   assign req_ready  = !s1_valid_ff || s1_go;
   assign req_accept = req_chan.valid && req_ready;

   assign req_chan.ready = req_ready;

   // ------------------------------------------------------------------------
   // Position counters. A frame start puts the pixel at row 0, column 0;
   // counts past the last index, which only a size change can cause, are
   // treated as being at the last index.
   // ------------------------------------------------------------------------
   logic [lbp_pkg::COL_W-1:0] col_ff;
   logic [lbp_pkg::COL_W-1:0] col_in;
   logic [lbp_pkg::ROW_W-1:0] row_ff;
   logic [lbp_pkg::ROW_W-1:0] row_in;
   logic [lbp_pkg::COL_W-1:0] col_base;
   logic [lbp_pkg::ROW_W-1:0] row_base;
   logic [lbp_pkg::COL_W-1:0] col_cur;
   logic [lbp_pkg::ROW_W-1:0] row_cur;
   lbp_pkg::tag_type          tag_cur;
   logic                      at_last_col;
   logic                      at_last_row;

   always_comb begin
      col_base    = req_chan.frame_start ? '0 : col_ff;
      row_base    = req_chan.frame_start ? '0 : row_ff;
      col_cur     = (col_base > col_last) ? col_last : col_base;
      row_cur     = (row_base > row_last) ? row_last : row_base;
      at_last_col = (col_cur == col_last);
      at_last_row = (row_cur == row_last);

      tag_cur.emit      = (row_cur >= lbp_pkg::ROW_W'(2)) && (col_cur >= lbp_pkg::COL_W'(2));
      tag_cur.row_end   = at_last_col;
      tag_cur.frame_end = at_last_col && at_last_row;

      if (at_last_col) begin
         col_in = '0;
         row_in = at_last_row ? '0 : row_cur + lbp_pkg::ROW_W'(1);
      end else begin
         col_in = col_cur + lbp_pkg::COL_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: the line stores are read at the pixel's column as the pixel is
   // taken, and written back with the shifted column once it moves on.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_tag_ff   <= tag_cur;
         s1_col_ff   <= col_cur;
         s1_pixel_ff <= req_chan.pixel;
      end
   end

   logic [lbp_pkg::PIX_W-1:0] line_up;
   logic [lbp_pkg::PIX_W-1:0] line_mid;

   // The row above moves into the upper store and the new pixel into the
   // middle store, so the stores always hold the two rows before the current.
   lbp_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_up   (line_mid),
      .wr_mid  (s1_pixel_ff),
      .rd_up   (line_up),
      .rd_mid  (line_mid)
   );

   // ------------------------------------------------------------------------
   // Stage 2: the window, a chain of three column cells. The right cell takes
   // the new column, and each cell hands its column to the left.
   // ------------------------------------------------------------------------
   lbp_pkg::win_col_type new_col;
   lbp_pkg::win_col_type left_col;
   lbp_pkg::win_col_type centre_col;
   lbp_pkg::win_col_type right_col;
   logic [2:0]           gt_left;
   logic [2:0]           gt_centre;
   logic [2:0]           gt_right;

   assign new_col.top = line_up;
   assign new_col.mid = line_mid;
   assign new_col.bot = s1_pixel_ff;

   lbp_cell u_cell_right (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_go),
      .col_in   (new_col),
      .centre   (centre_col.mid),
      .col_out  (right_col),
      .gt_bits  (gt_right)
   );

   lbp_cell u_cell_centre (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_go),
      .col_in   (right_col),
      .centre   (centre_col.mid),
      .col_out  (centre_col),
      .gt_bits  (gt_centre)
   );

   lbp_cell u_cell_left (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_go),
      .col_in   (centre_col),
      .centre   (centre_col.mid),
      .col_out  (left_col),
      .gt_bits  (gt_left)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // Code bits run clockwise from the top-left neighbor down to the left one.
   logic [lbp_pkg::CODE_W-1:0] code_cur;

   assign code_cur = {gt_left[2], gt_centre[2], gt_right[2], gt_right[1],
                      gt_right[0], gt_centre[0], gt_left[0], gt_left[1]};

   // ------------------------------------------------------------------------
   // Result register. It keeps its beat while the receiver stalls.
   // ------------------------------------------------------------------------
   logic [lbp_pkg::CODE_W-1:0] rsp_code_ff;
   logic                       rsp_row_end_ff;
   logic                       rsp_frame_end_ff;
   logic                       rsp_load;

   assign rsp_load = s2_go && s2_tag_ff.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_code_ff      <= code_cur;
         rsp_row_end_ff   <= s2_tag_ff.row_end;
         rsp_frame_end_ff <= s2_tag_ff.frame_end;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.lbp_code  = rsp_code_ff;
   assign rsp_chan.row_end   = rsp_row_end_ff;
   assign rsp_chan.frame_end = rsp_frame_end_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `LBP_ASSERT_SAME(a_stall_only_when_full, !req_ready, s2_valid_ff && rsp_valid_ff, "input stalled while the pipeline had room")
   `LBP_ASSERT_NEXT(a_accept_fills_s1, req_accept, s1_valid_ff, "accepted pixel did not reach stage 1")
   `LBP_ASSERT_NEXT(a_emit_loads_rsp, rsp_load, rsp_valid_ff, "interior pixel produced no result beat")
   `LBP_ASSERT_SAME(a_frame_end_is_row_end, rsp_valid_ff && rsp_frame_end_ff, rsp_row_end_ff, "frame end without row end")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lbp_code_stream_unit. Grey pixels are streamed in
// raster order through several frame sizes, from the smallest to the widest
// and the tallest, with random idle and stall bursts on both channels. Every
// accepted pixel steps a bit-exact software copy of the block; the codes it
// predicts are queued and compared field by field with the beats that leave
// the result channel.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD = 4;
   localparam int RESET_CYCLES = 8;
   // Border pixels leave no beat behind and may still be in the pipeline, so a
   // config write waits this long after the last expected code has arrived.
   localparam int SETTLE_CYCLES = 8;
   // Longest quiet stretch in a healthy run is the deliberate receiver
   // hold-off (HOLD_OFF_CYCLES); the watchdog limit QUIET_LIMIT lies above it.
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASE_PIXELS = 80;
   localparam int RANDOM_PHASES = 8;
   localparam int WIDE_PIXELS = 40;

   // One code beat as it leaves the block.
   typedef struct packed {
      logic [lbp_pkg::CODE_W-1:0] code;
      logic                       row_end;
      logic                       frame_end;
   } code_beat_type;

   // One row of the directed table. Where typed is set, the expected beat
   // is given in the row itself; elsewhere the predictor decides.
   typedef struct packed {
      logic [lbp_pkg::PIX_W-1:0]  pixel;
      logic                       frame_start;
      logic                       typed;
      logic [lbp_pkg::CODE_W-1:0] code;
      logic                       row_end;
      logic                       frame_end;
   } stimulus_row_type;

   // The directed table runs at an effective 3x3 frame. The first pixel
   // lands right after a mid-frame shrink from the reset size and closes
   // that frame. Then: a frame of bright neighbors around a black center,
   // a frame entered by wrap-around alone that checks the top-left bit and
   // strict comparison, one stray pixel, and a frame started mid-frame with
   // a white center that no neighbor can exceed.
   localparam int DIRECTED_ROWS = 29;
   localparam stimulus_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h40, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1},
      '{8'h09, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h05, 1'b0, 1'b1, 8'h80, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1}
   };

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [0:0] csr_index;
   logic [lbp_pkg::CSR_DATA_W-1:0] csr_wdata;

   lbp_req_if req_bus ();
   lbp_rsp_if rsp_bus ();

   lbp_code_stream_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Software copy of the block: frame size registers, the two line stores,
   // the 3x3 window and the raster position.
   logic [lbp_pkg::CFG_WIDTH_W-1:0]  cfg_width;
   logic [lbp_pkg::CFG_HEIGHT_W-1:0] cfg_height;
   logic [lbp_pkg::PIX_W-1:0] upper_row [lbp_pkg::MAX_WIDTH];
   logic [lbp_pkg::PIX_W-1:0] middle_row [lbp_pkg::MAX_WIDTH];
   logic [lbp_pkg::PIX_W-1:0] win [9];
   int unsigned col_pos;
   int unsigned row_pos;

   code_beat_type pending_codes [$];
   int mismatch_count;
   int quiet_cycles;
   bit idling;
   bit need_start;
   int sink_hold;

   initial clock = 1'b0;
   always #(PERIOD / 2) clock = ~clock;

   // Widths are clamped to 3..MAX_WIDTH and heights to at least 3.
   function automatic int unsigned active_width();
      int unsigned w;
      w = cfg_width;
      if (w < 3) w = 3;
      if (w > lbp_pkg::MAX_WIDTH) w = lbp_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = cfg_height;
      if (h < 3) h = 3;
      return h;
   endfunction

   // Steps the copy by one pixel. Returns 1 when the pixel completes the
   // window of an interior pixel, with the code beat that it yields.
   function automatic bit lbp_next_code(input logic [lbp_pkg::PIX_W-1:0] px,
                                        input logic fs, output code_beat_type beat);
      int unsigned w, h, c, r;
      logic [lbp_pkg::PIX_W-1:0] centre;
      bit emit;
      w = active_width();
      h = active_height();
      beat = '0;
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      // A position left past the end by a shrinking frame size counts as
      // the last column or row.
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      win[0] = win[1];
      win[1] = win[2];
      win[3] = win[4];
      win[4] = win[5];
      win[6] = win[7];
      win[7] = win[8];
      win[2] = upper_row[c];
      win[5] = middle_row[c];
      win[8] = px;
      upper_row[c] = middle_row[c];
      middle_row[c] = px;
      centre = win[4];
      emit = (r >= 2) && (c >= 2);
      if (emit) begin
         // Top-left first, then clockwise around the center to the left.
         beat.code = {win[0] > centre, win[1] > centre, win[2] > centre, win[5] > centre,
                      win[8] > centre, win[7] > centre, win[6] > centre, win[3] > centre};
         beat.row_end = (c == w - 1);
         beat.frame_end = (c == w - 1) && (r == h - 1);
      end
      if (c == w - 1) begin
         col_pos = 0;
         row_pos = (r == h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      return emit;
   endfunction

   // Pixel levels: a narrow band that gives many equal neighbors, the two
   // extremes, and the full range.
   function automatic logic [lbp_pkg::PIX_W-1:0] grey_level();
      case ($urandom_range(0, 3))
         0: return lbp_pkg::PIX_W'($urandom_range(126, 129));
         1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: return lbp_pkg::PIX_W'($urandom);
      endcase
   endfunction

   // Offers one pixel beat and waits until it is taken. Called at a falling
   // edge and returns at the falling edge after the beat was accepted, with
   // valid still high so that a following beat can go out without a gap.
   task automatic send_pixel(input logic [lbp_pkg::PIX_W-1:0] px, input logic fs,
                             input bit typed, input code_beat_type typed_beat);
      code_beat_type beat;
      bit emit;
      if (idling && $urandom_range(0, 11) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= px;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      emit = lbp_next_code(px, fs, beat);
      if (typed) pending_codes.push_back(typed_beat);
      else if (emit) pending_codes.push_back(beat);
      @(negedge clock);
   endtask

   // Stops the pixel stream, waits until every expected code has arrived
   // and the pipeline has settled, then writes both frame size registers.
   task automatic write_frame_size(input logic [lbp_pkg::CSR_DATA_W-1:0] width_data,
                                   input logic [lbp_pkg::CSR_DATA_W-1:0] height_data);
      req_bus.valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= lbp_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= width_data;
      @(negedge clock);
      csr_index <= lbp_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= height_data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      cfg_width = width_data[lbp_pkg::CFG_WIDTH_W-1:0];
      cfg_height = height_data;
   endtask

   // Streams one frame at the current size. Most frames are whole and
   // begin with frame_start; a few drop that flag and rely on wrap-around,
   // and some are cut short and followed by a frame_start mid-frame.
   task automatic stream_frame(input bit may_break, inout int unsigned sent);
      int unsigned total, stop, k;
      logic fs;
      total = active_width() * active_height();
      stop = total;
      if (may_break && $urandom_range(0, 9) == 0) stop = $urandom_range(1, total - 1);
      for (k = 0; k < stop; k++) begin
         fs = (k == 0) && (need_start || $urandom_range(0, 7) != 0);
         send_pixel(grey_level(), fs, 1'b0, '0);
      end
      need_start = (stop != total);
      sent += stop;
   endtask

   // Result side. Ready stalls in random bursts while idling is on, and
   // drops for a long stretch when the stimulus asks for a hold-off, which
   // backs the pipeline up until the block refuses pixels.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (sink_hold) @(negedge clock);
            sink_hold = 0;
            rsp_bus.ready <= 1'b1;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Each code beat is matched against the oldest prediction.
   always @(posedge clock) begin : code_check
      code_beat_type want;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_codes.size() == 0) begin
            $error("unexpected code beat: lbp_code %02h", rsp_bus.lbp_code);
            mismatch_count++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_bus.lbp_code !== want.code) begin
               $error("lbp_code: expected %02h, got %02h", want.code, rsp_bus.lbp_code);
               mismatch_count++;
            end
            if (rsp_bus.row_end !== want.row_end) begin
               $error("row_end: expected %0b, got %0b", want.row_end, rsp_bus.row_end);
               mismatch_count++;
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_bus.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: ends a run in which no beat moves on either channel, with a
   // mismatch report.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned sent, i, ph;
      logic [lbp_pkg::CSR_DATA_W-1:0] width_data, height_data;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      req_bus.frame_start = 1'b0;
      csr_write_en = 1'b0;
      csr_index = lbp_pkg::CSR_FRAME_WIDTH;
      csr_wdata = '0;
      mismatch_count = 0;
      quiet_cycles = 0;
      sink_hold = 0;
      idling = 1'b1;
      need_start = 1'b1;
      cfg_width = lbp_pkg::WIDTH_RESET;
      cfg_height = lbp_pkg::HEIGHT_RESET;
      foreach (win[j]) win[j] = '0;
      foreach (upper_row[j]) upper_row[j] = '0;
      foreach (middle_row[j]) middle_row[j] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // At the reset size of 128 columns, two full rows and three pixels of
      // the third give the first interior code, which checks the default
      // width. The frame is then cut to 3x3 while it sits at column 3 of
      // row 2, so its next pixel closes the frame from past the new edge.
      for (i = 0; i < 2 * 128 + 3; i++) send_pixel(grey_level(), i == 0, 1'b0, '0);
      write_frame_size(16'h0000, 16'h0002);

      foreach (DIRECTED[n])
         send_pixel(DIRECTED[n].pixel, DIRECTED[n].frame_start, DIRECTED[n].typed,
                    {DIRECTED[n].code, DIRECTED[n].row_end, DIRECTED[n].frame_end});

      // Tallest frame: a few rows at height 65535 with junk in the upper
      // width bits, then the height drops mid-frame below the current row,
      // which becomes the last one.
      write_frame_size(16'hF003, 16'hFFFF);
      for (i = 0; i < 15; i++) send_pixel(grey_level(), i == 0, 1'b0, '0);
      write_frame_size(16'h0003, 16'h0001);
      for (i = 0; i < 3; i++) send_pixel(grey_level(), 1'b0, 1'b0, '0);
      sent = 0;
      need_start = 1'b0;
      stream_frame(1'b1, sent);
      stream_frame(1'b1, sent);

      // Widest line: a width above the line store size clamps to 2048. Only
      // the start of the first row goes in, which walks the column count
      // past every narrow width without producing a code.
      write_frame_size(16'h0FFF, 16'h0000);
      for (i = 0; i < WIDE_PIXELS; i++) send_pixel(grey_level(), i == 0, 1'b0, '0);

      // Random small sizes. A phase always opens with frame_start
      // so that a wider frame never reads line store entries left unwritten.
      // One phase holds the receiver off while pixels keep coming, and the
      // last phases run with no idling at all.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         width_data = {4'($urandom), 12'($urandom_range(0, 12))};
         height_data = lbp_pkg::CSR_DATA_W'($urandom_range(0, 8));
         if (ph == 3) begin
            width_data = 16'd5;
            height_data = 16'd8;
         end
         if (ph >= RANDOM_PHASES - 3) idling = 1'b0;
         write_frame_size(width_data, height_data);
         need_start = 1'b1;
         if (ph == 3) sink_hold = HOLD_OFF_CYCLES;
         sent = 0;
         while (sent < PHASE_PIXELS) stream_frame(1'b1, sent);
      end

      req_bus.valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES * 2) @(negedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
